// ----- design/cta_pkg.sv -----
// Shared widths, constants and character tables for the clock time/alarm command parser.
package cta_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned HOURS_W   = 5;
  localparam int unsigned MINUTES_W = 6;
  localparam int unsigned SECONDS_W = 6;
  localparam int unsigned FIELDS_W  = 24;

  localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'd60;  // '<'
  localparam logic [BYTE_W-1:0] ASCII_ZERO       = 8'd48;
  localparam logic [BYTE_W-1:0] HOURS_LIMIT      = 8'd24;
  localparam logic [BYTE_W-1:0] MINSEC_LIMIT     = 8'd60;

  localparam logic [POS_W-1:0] POS_MAX        = 4'd15;
  localparam logic [POS_W-1:0] TIME_BODY_LEN  = 4'd13;
  localparam logic [POS_W-1:0] ALARM_BODY_LEN = 4'd14;
  localparam logic [POS_W-1:0] TIME_WORD_LEN  = 4'd5;
  localparam logic [POS_W-1:0] ALARM_WORD_LEN = 4'd6;
  localparam logic [POS_W-1:0] TIME_DIGIT_BASE  = 4'd5;
  localparam logic [POS_W-1:0] ALARM_DIGIT_BASE = 4'd6;

  localparam logic [0:0] STATUS_OK    = 1'b0;
  localparam logic [0:0] STATUS_ERROR = 1'b1;
  localparam logic [0:0] TARGET_TIME  = 1'b0;
  localparam logic [0:0] TARGET_ALARM = 1'b1;

  // "TIME "
  function automatic logic [BYTE_W-1:0] time_word_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h49;
      4'd2:    c = 8'h4D;
      4'd3:    c = 8'h45;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "ALARM "
  function automatic logic [BYTE_W-1:0] alarm_word_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      4'd0:    c = 8'h41;
      4'd1:    c = 8'h4C;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h52;
      4'd4:    c = 8'h4D;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// ----- design/cta_cmd_if.sv -----
// Command byte channel: valid/ready handshake carrying one message byte per item.
interface cta_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [cta_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/cta_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one parse result per item.
interface cta_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          target;
  logic [cta_pkg::HOURS_W-1:0]   hours;
  logic [cta_pkg::MINUTES_W-1:0] minutes;
  logic [cta_pkg::SECONDS_W-1:0] seconds;

  modport source (output valid, output status, output target, output hours,
                  output minutes, output seconds, input ready);
  modport sink   (input valid, input status, input target, input hours,
                  input minutes, input seconds, output ready);
endinterface

// ----- design/clock_time_alarm_command_parser.sv -----
// Clock time/alarm command parser top level.
//
// Parses framed "<TIME HH:MM:SS" / "<ALARM HH:MM:SS" messages one byte per item
// and gives one result item (ok with the loaded time or alarm, or error) on the
// byte flagged last; other bytes give no result. Each byte passes an input
// register, then compare/accumulate logic into the state/result registers,
// so a byte can be taken every cycle; a last byte waits in the input register
// only while a previous result is still held on the response channel.
module clock_time_alarm_command_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [cta_pkg::BYTE_W-1:0] cfg_wr_data,
  cta_cmd_if.sink                    cmd,
  cta_rsp_if.source                  rsp
);
  import cta_pkg::*;

  logic [BYTE_W-1:0] start_char;

  // input register
  logic              s_valid;
  logic [BYTE_W-1:0] s_byte;
  logic              s_last;
  logic              s_adv;

  // message state
  logic                in_frame;
  logic [POS_W-1:0]    body_position;
  logic                start_ok;
  logic                time_prefix_match;
  logic                alarm_prefix_match;
  logic [FIELDS_W-1:0] time_fields;
  logic [FIELDS_W-1:0] alarm_fields;
  logic [FIELDS_W-1:0] clock_setting;
  logic [FIELDS_W-1:0] alarm_setting;

  logic                in_frame_next;
  logic [POS_W-1:0]    body_position_next;
  logic                start_ok_next;
  logic                time_prefix_match_next;
  logic                alarm_prefix_match_next;
  logic [FIELDS_W-1:0] time_fields_next;
  logic [FIELDS_W-1:0] alarm_fields_next;

  // result register
  logic                 out_valid;
  logic                 out_status;
  logic                 out_target;
  logic [HOURS_W-1:0]   out_hours;
  logic [MINUTES_W-1:0] out_minutes;
  logic [SECONDS_W-1:0] out_seconds;

  logic                time_ok;
  logic                alarm_ok;
  logic [FIELDS_W-1:0] res_fields;

  function automatic logic fields_valid(input logic [FIELDS_W-1:0] f);
    return (f[23:16] < HOURS_LIMIT) && (f[15:8] < MINSEC_LIMIT) && (f[7:0] < MINSEC_LIMIT);
  endfunction

  // base is the body position of the first hours digit
  function automatic logic [FIELDS_W-1:0] take_digit(input logic [FIELDS_W-1:0] fields,
                                                     input logic [POS_W-1:0]    pos,
                                                     input logic [POS_W-1:0]    base,
                                                     input logic [BYTE_W-1:0]   b);
    logic [FIELDS_W-1:0] f;
    logic [BYTE_W-1:0]   d;
    logic [BYTE_W-1:0]   cur;
    logic [POS_W:0]      first;
    f = fields;
    d = b - ASCII_ZERO;
    for (int k = 0; k < 3; k++) begin
      first = {1'b0, base} + 5'(3 * k);
      cur   = f[16 - 8*k +: 8];
      if ({1'b0, pos} == first) begin
        f[16 - 8*k +: 8] = {d[4:0], 3'b000} + {d[6:0], 1'b0};
      end else if ({1'b0, pos} == first + 5'd1) begin
        f[16 - 8*k +: 8] = cur + d;
      end
    end
    return f;
  endfunction

  assign s_adv     = s_valid && (!s_last || !out_valid || rsp.ready);
  assign cmd.ready = !s_valid || s_adv;

  always_comb begin
    in_frame_next           = in_frame;
    body_position_next      = body_position;
    start_ok_next           = start_ok;
    time_prefix_match_next  = time_prefix_match;
    alarm_prefix_match_next = alarm_prefix_match;
    time_fields_next        = time_fields;
    alarm_fields_next       = alarm_fields;
    if (!in_frame) begin
      in_frame_next = 1'b1;
      start_ok_next = (s_byte == start_char);
    end else begin
      if (body_position < TIME_WORD_LEN && s_byte != time_word_char(body_position)) begin
        time_prefix_match_next = 1'b0;
      end
      if (body_position < ALARM_WORD_LEN && s_byte != alarm_word_char(body_position)) begin
        alarm_prefix_match_next = 1'b0;
      end
      time_fields_next  = take_digit(time_fields, body_position, TIME_DIGIT_BASE, s_byte);
      alarm_fields_next = take_digit(alarm_fields, body_position, ALARM_DIGIT_BASE, s_byte);
      if (body_position != POS_MAX) begin
        body_position_next = body_position + 4'd1;
      end
    end
  end

  always_comb begin
    time_ok  = 1'b0;
    alarm_ok = 1'b0;
    if (start_ok_next) begin
      if (body_position_next == TIME_BODY_LEN && time_prefix_match_next) begin
        time_ok = fields_valid(time_fields_next);
      end else if (body_position_next == ALARM_BODY_LEN && alarm_prefix_match_next) begin
        alarm_ok = fields_valid(alarm_fields_next);
      end
    end
    res_fields = alarm_ok ? alarm_fields_next : time_fields_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RESET;
    end else if (cfg_wr_en) begin
      start_char <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd.ready) begin
      s_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s_byte <= cmd.data_byte;
      s_last <= cmd.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame           <= 1'b0;
      body_position      <= '0;
      start_ok           <= 1'b0;
      time_prefix_match  <= 1'b1;
      alarm_prefix_match <= 1'b1;
      time_fields        <= '0;
      alarm_fields       <= '0;
      clock_setting      <= '0;
      alarm_setting      <= '0;
    end else if (s_adv) begin
      if (s_last) begin
        in_frame           <= 1'b0;
        body_position      <= '0;
        start_ok           <= 1'b0;
        time_prefix_match  <= 1'b1;
        alarm_prefix_match <= 1'b1;
        time_fields        <= '0;
        alarm_fields       <= '0;
        if (time_ok) begin
          clock_setting <= time_fields_next;
        end
        if (alarm_ok) begin
          alarm_setting <= alarm_fields_next;
        end
      end else begin
        in_frame           <= in_frame_next;
        body_position      <= body_position_next;
        start_ok           <= start_ok_next;
        time_prefix_match  <= time_prefix_match_next;
        alarm_prefix_match <= alarm_prefix_match_next;
        time_fields        <= time_fields_next;
        alarm_fields       <= alarm_fields_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_adv && s_last) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_last) begin
      out_status  <= (time_ok || alarm_ok) ? STATUS_OK : STATUS_ERROR;
      out_target  <= alarm_ok ? TARGET_ALARM : TARGET_TIME;
      out_hours   <= (time_ok || alarm_ok) ? res_fields[20:16] : '0;
      out_minutes <= (time_ok || alarm_ok) ? res_fields[13:8] : '0;
      out_seconds <= (time_ok || alarm_ok) ? res_fields[5:0] : '0;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.target  = out_target;
  assign rsp.hours   = out_hours;
  assign rsp.minutes = out_minutes;
  assign rsp.seconds = out_seconds;

endmodule

// ----- verif/clock_time_alarm_command_parser_tb.sv -----
// Self-checking testbench for the clock time/alarm command parser.
`timescale 1ns / 1ps

module clock_time_alarm_command_parser_tb;
  import cta_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 330;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cmd_byte_t;

  typedef struct packed {
    logic                 status;
    logic                 target;
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [BYTE_W-1:0] cfg_wr_data = '0;
  logic              cmd_valid   = 1'b0;
  logic [BYTE_W-1:0] cmd_data    = '0;
  logic              cmd_last    = 1'b0;
  logic              rsp_ready   = 1'b0;

  cta_cmd_if cmd_ch();
  cta_rsp_if rsp_ch();

  assign cmd_ch.valid     = cmd_valid;
  assign cmd_ch.data_byte = cmd_data;
  assign cmd_ch.last_byte = cmd_last;
  assign rsp_ch.ready     = rsp_ready;

  clock_time_alarm_command_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser mirror state
  logic [BYTE_W-1:0]   start_char_cfg = START_CHAR_RESET;
  logic                in_frame       = 1'b0;
  logic [POS_W-1:0]    body_pos       = '0;
  logic                start_ok       = 1'b0;
  logic                time_kw_ok     = 1'b1;
  logic                alarm_kw_ok    = 1'b1;
  logic [FIELDS_W-1:0] time_acc       = '0;
  logic [FIELDS_W-1:0] alarm_acc      = '0;
  logic [FIELDS_W-1:0] clock_value    = '0;
  logic [FIELDS_W-1:0] alarm_value    = '0;
  string time_kw  = "TIME ";
  string alarm_kw = "ALARM ";

  cmd_byte_t     pending_items[$];
  parse_result_t expected_results[$];
  logic [BYTE_W-1:0] frame_buf[$];

  int mismatches     = 0;
  int bytes_accepted = 0;
  int queued_items   = 0;
  int frames_sent    = 0;
  int time_loads     = 0;
  int alarm_loads    = 0;
  int rejects        = 0;
  int cycle_count    = 0;

  function automatic logic [FIELDS_W-1:0] accumulate_digit(input logic [FIELDS_W-1:0] acc,
      input int unsigned pos, input int unsigned base, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] cur;
    int unsigned k;
    int unsigned first;
    int unsigned lo;
    d = b - ASCII_ZERO;
    for (k = 0; k < 3; k++) begin
      first = base + 3 * k;
      lo = 16 - 8 * k;
      cur = acc[lo +: 8];
      if (pos == first) begin
        cur = d * 8'd10;
        acc[lo +: 8] = cur;
      end else if (pos == first + 1) begin
        cur = cur + d;
        acc[lo +: 8] = cur;
      end
    end
    return acc;
  endfunction

  function automatic logic fields_in_range(input logic [FIELDS_W-1:0] f);
    return f[23:16] < HOURS_LIMIT && f[15:8] < MINSEC_LIMIT && f[7:0] < MINSEC_LIMIT;
  endfunction

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned p;
    logic ok;
    logic to_alarm;
    logic [FIELDS_W-1:0] f;
    parse_result_t r;
    ok = 1'b0;
    to_alarm = 1'b0;
    f = '0;
    bytes_accepted++;
    if (!in_frame) begin
      in_frame = 1'b1;
      start_ok = (b == start_char_cfg);
    end else begin
      p = 32'(body_pos);
      if (p < 5 && b != time_kw[p]) time_kw_ok = 1'b0;
      if (p < 6 && b != alarm_kw[p]) alarm_kw_ok = 1'b0;
      time_acc  = accumulate_digit(time_acc, p, 32'(TIME_DIGIT_BASE), b);
      alarm_acc = accumulate_digit(alarm_acc, p, 32'(ALARM_DIGIT_BASE), b);
      if (body_pos != POS_MAX) body_pos = body_pos + 4'd1;
    end
    if (last) begin
      if (start_ok) begin
        if (body_pos == TIME_BODY_LEN && time_kw_ok) begin
          if (fields_in_range(time_acc)) begin
            ok = 1'b1;
            f = time_acc;
            clock_value = f;
          end
        end else if (body_pos == ALARM_BODY_LEN && alarm_kw_ok) begin
          if (fields_in_range(alarm_acc)) begin
            ok = 1'b1;
            to_alarm = 1'b1;
            f = alarm_acc;
            alarm_value = f;
          end
        end
      end
      r.status  = ok ? STATUS_OK : STATUS_ERROR;
      r.target  = to_alarm ? TARGET_ALARM : TARGET_TIME;
      r.hours   = ok ? f[20:16] : '0;
      r.minutes = ok ? f[13:8] : '0;
      r.seconds = ok ? f[5:0] : '0;
      expected_results.push_back(r);
      if (!ok) rejects++;
      else if (to_alarm) alarm_loads++;
      else time_loads++;
      // message state clears after every last byte; stored settings stay
      in_frame    = 1'b0;
      body_pos    = '0;
      start_ok    = 1'b0;
      time_kw_ok  = 1'b1;
      alarm_kw_ok = 1'b1;
      time_acc    = '0;
      alarm_acc   = '0;
    end
  endtask

  // ---------------- frame building ----------------

  function automatic logic [BYTE_W-1:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // skewed toward the range ends
  function automatic int pick_value(input int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return limit - 1;
    return $urandom_range(0, limit - 1);
  endfunction

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  task automatic push_two_digits(input int v);
    logic [BYTE_W-1:0] c;
    c = 8'(ASCII_ZERO + v / 10);
    frame_buf.push_back(c);
    c = 8'(ASCII_ZERO + v % 10);
    frame_buf.push_back(c);
  endtask

  task automatic build_command(input logic to_alarm, input int h, input int m, input int s);
    logic [BYTE_W-1:0] sep1;
    logic [BYTE_W-1:0] sep2;
    sep1 = $urandom_range(0, 1) ? 8'h3A : rand_byte();
    sep2 = $urandom_range(0, 1) ? 8'h3A : rand_byte();
    frame_buf.delete();
    frame_buf.push_back(start_char_cfg);
    push_text(to_alarm ? alarm_kw : time_kw);
    push_two_digits(h);
    frame_buf.push_back(sep1);
    push_two_digits(m);
    frame_buf.push_back(sep2);
    push_two_digits(s);
  endtask

  task automatic send_frame();
    cmd_byte_t it;
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      it.data = frame_buf[i];
      it.last = (i == frame_buf.size() - 1);
      pending_items.push_back(it);
    end
    queued_items += frame_buf.size();
    frames_sent++;
    frame_buf.delete();
  endtask

  task automatic queue_random_frame();
    int kind;
    int n;
    int i;
    int base;
    logic to_alarm;
    kind = $urandom_range(0, 99);
    to_alarm = 1'($urandom_range(0, 1));
    base = to_alarm ? 32'(ALARM_DIGIT_BASE) : 32'(TIME_DIGIT_BASE);
    if (kind >= 90) begin
      frame_buf.delete();
      frame_buf.push_back($urandom_range(0, 1) ? start_char_cfg : rand_byte());
      if (kind >= 95) begin
        n = $urandom_range(1, 20);
        for (i = 1; i < n; i++) frame_buf.push_back(rand_byte());
      end
    end else begin
      if (kind >= 40 && kind < 50)
        build_command(to_alarm, $urandom_range(0, 99), $urandom_range(0, 99),
                      $urandom_range(0, 99));
      else
        build_command(to_alarm, pick_value(24), pick_value(60), pick_value(60));
      if (kind >= 50 && kind < 58) begin
        // arbitrary bytes in the digit slots
        for (i = 0; i < 8; i++)
          if (i % 3 != 2 && $urandom_range(0, 1)) frame_buf[1 + base + i] = rand_byte();
      end else if (kind >= 58 && kind < 68) begin
        frame_buf[$urandom_range(1, base)] = rand_byte();
      end else if (kind >= 68 && kind < 76) begin
        frame_buf[0] = rand_byte();
      end else if (kind >= 76) begin
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) begin
          for (i = 0; i < n && i < 3; i++) void'(frame_buf.pop_back());
        end else begin
          for (i = 0; i < n; i++) frame_buf.push_back(rand_byte());
        end
      end
    end
    send_frame();
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || cmd_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------- driver ----------------

  cmd_byte_t next_byte;
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_data  <= '0;
      cmd_last  <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ch.ready) parse_byte(cmd_data, cmd_last);
      if (!cmd_valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_byte = pending_items.pop_front();
          cmd_valid <= 1'b1;
          cmd_data  <= next_byte.data;
          cmd_last  <= next_byte.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  parse_result_t got;
  parse_result_t want;
  int ready_pct = 100;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        got.status  = rsp_ch.status;
        got.target  = rsp_ch.target;
        got.hours   = rsp_ch.hours;
        got.minutes = rsp_ch.minutes;
        got.seconds = rsp_ch.seconds;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: status=%0d target=%0d %0d:%0d:%0d", $realtime,
                     got.status, got.target, got.hours, got.minutes, got.seconds);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.target !== want.target ||
              got.hours !== want.hours || got.minutes !== want.minutes ||
              got.seconds !== want.seconds) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: expected status=%0d target=%0d %0d:%0d:%0d, got status=%0d target=%0d %0d:%0d:%0d",
                       $realtime, want.status, want.target, want.hours, want.minutes,
                       want.seconds, got.status, got.target, got.hours, got.minutes,
                       got.seconds);
          end
        end
      end
      stall_tick++;
      if (stall_tick % 256 == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d items queued and %0d results outstanding",
               cycle_count, pending_items.size(), expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  logic [BYTE_W-1:0] start_values [4];
  int phase_idx;
  int phase_goal;

  initial begin
    start_values[0] = 8'd0;
    start_values[1] = 8'd255;
    start_values[2] = rand_byte();
    start_values[3] = START_CHAR_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: top of range, bottom of range, empty body
    build_command(TARGET_TIME, 23, 59, 59);
    send_frame();
    build_command(TARGET_ALARM, 0, 0, 0);
    send_frame();
    frame_buf.push_back(start_char_cfg);
    send_frame();
    wait_until_drained();

    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= start_values[phase_idx];
      start_char_cfg = start_values[phase_idx];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      phase_goal = queued_items + PHASE_ITEMS;
      while (queued_items < phase_goal) queue_random_frame();
      wait_until_drained();
    end

    $display("Sent %0d messages (%0d bytes) with the reset start character and four written ones, 0 and 255 among them.",
             frames_sent, bytes_accepted);
    $display("Results: %0d time loads, %0d alarm loads, %0d rejected; %0d mismatches.",
             time_loads, alarm_loads, rejects, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- clock_time_alarm_command_parser.f -----
design/cta_pkg.sv
design/cta_cmd_if.sv
design/cta_rsp_if.sv
design/clock_time_alarm_command_parser.sv
verif/clock_time_alarm_command_parser_tb.sv
